// ===== rtl/hsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, constants and the CRC-16 byte step for the HDLC stream
// deframer with FCS check.
// ----------------------------------------------------------------------------
package hsd_pkg;

   // Line codes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   // FCS-16, reflected form
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_GOOD = 16'hF0B8;

   // Frame limits
   localparam int          MAX_FRAME = 4096;
   localparam int          CNT_W     = 13;
   localparam int          IDX_W     = 12;
   localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] MIN_CLOSE = CNT_W'(3);
   localparam logic [CNT_W-1:0] FCS_LEN   = CNT_W'(2);

   // Queue depth between stages and on the result side
   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   // Frame status codes
   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_GOOD     = 2'd1,
      ST_CRC_ERR  = 2'd2,
      ST_OVERFLOW = 2'd3
   } frame_status_type;

   // Classified line byte, passed from front to back
   typedef struct packed {
      logic       is_flag;
      logic       is_esc;
      logic [7:0] rx_byte;
   } item_type;

   // One result word
   typedef struct packed {
      logic                  data_valid;
      logic [7:0]            data_byte;
      logic [IDX_W-1:0]      data_index;
      frame_status_type      frame_status;
      logic [IDX_W-1:0]      payload_len;
   } result_type;

   // One byte through the reflected CRC, bit by bit (eight steps)
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/hsd_front.sv =====
// ----------------------------------------------------------------------------
// hsd_front
// Accepts raw line bytes, tags flags and escapes, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [7:0]       req_rx_byte,
   output logic             item_valid,
   output hsd_pkg::item_type item_out,
   input  logic             item_take
);
   import hsd_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       wr_en;
   logic       rd_en;
   item_type   item_new;

   // Classify the incoming word
   always_comb begin
      item_new.rx_byte = req_rx_byte;
      item_new.is_flag = (req_rx_byte == FLAG_BYTE);
      item_new.is_esc  = (req_rx_byte == ESC_BYTE);
   end

   assign full       = (count_ff == QUEUE_DEPTH);
   assign item_valid = (count_ff != 2'd0);
   assign item_out   = q_ff[rd_ptr_ff];
   assign wr_en      = push && !full;
   assign rd_en      = item_take && item_valid;

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ===== rtl/hsd_back.sv =====
// ----------------------------------------------------------------------------
// hsd_back
// Frame state, destuffing, CRC accumulation and length check. Each word
// taken from the front produces one result word into a two-entry queue.
// ----------------------------------------------------------------------------
module hsd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [12:0]         csr_wr_data,
   input  logic                item_valid,
   input  hsd_pkg::item_type   item_in,
   output logic                item_take,
   output logic                empty,
   input  logic                pop,
   output hsd_pkg::result_type res_out
);
   import hsd_pkg::*;

   // Frame state
   logic              in_frame_ff, in_frame_in;
   logic              esc_pending_ff, esc_pending_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [15:0]       crc_acc_ff, crc_acc_in;
   logic [CNT_W-1:0]  max_length_ff;

   // Result queue
   result_type        rq_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              res_push;
   logic              res_pop;
   result_type        res_in;

   logic [CNT_W-1:0]  cap;
   logic [CNT_W-1:0]  count_inc;
   logic [7:0]        data_b;
   logic [15:0]       crc_next;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= CAP_LIMIT;
      end else if (csr_wr_en) begin
         max_length_ff <= csr_wr_data;
      end
   end

   // Handshake between the word queue and the result queue
   assign res_pop   = pop && !empty;
   assign item_take = item_valid && ((count_ff != QUEUE_DEPTH) || res_pop);
   assign res_push  = item_take;
   assign empty     = (count_ff == 2'd0);
   assign res_out   = rq_ff[rd_ptr_ff];

   // Datapath helpers
   assign cap       = (max_length_ff > CAP_LIMIT) ? CAP_LIMIT : max_length_ff;
   assign count_inc = byte_count_ff + CNT_W'(1);
   assign data_b    = esc_pending_ff ? (item_in.rx_byte ^ ESC_XOR) : item_in.rx_byte;
   assign crc_next  = crc_byte(crc_acc_ff, data_b);

   // Frame decode
   always_comb begin
      in_frame_in    = in_frame_ff;
      esc_pending_in = esc_pending_ff;
      byte_count_in  = byte_count_ff;
      crc_acc_in     = crc_acc_ff;
      res_in         = '0;
      res_in.frame_status = ST_NONE;
      if (!in_frame_ff) begin
         // hunting for the opening flag
         if (item_in.is_flag) begin
            in_frame_in    = 1'b1;
            esc_pending_in = 1'b0;
            crc_acc_in     = CRC_INIT;
         end
      end else if (item_in.is_flag) begin
         // closing flag; short frames stay open
         if (byte_count_ff >= MIN_CLOSE) begin
            if (crc_acc_ff == CRC_GOOD) begin
               res_in.frame_status = ST_GOOD;
               res_in.payload_len  = IDX_W'(byte_count_ff - FCS_LEN);
            end else begin
               res_in.frame_status = ST_CRC_ERR;
            end
            in_frame_in    = 1'b0;
            esc_pending_in = 1'b0;
            byte_count_in  = '0;
            crc_acc_in     = CRC_INIT;
         end
      end else if (item_in.is_esc) begin
         esc_pending_in = 1'b1;
      end else begin
         // stored byte
         res_in.data_valid = 1'b1;
         res_in.data_byte  = data_b;
         res_in.data_index = byte_count_ff[IDX_W-1:0];
         esc_pending_in    = 1'b0;
         crc_acc_in        = crc_next;
         byte_count_in     = count_inc;
         if (count_inc >= cap) begin
            res_in.frame_status = ST_OVERFLOW;
            in_frame_in    = 1'b0;
            byte_count_in  = '0;
            crc_acc_in     = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         esc_pending_ff <= 1'b0;
         byte_count_ff  <= '0;
         crc_acc_ff     <= CRC_INIT;
      end else if (item_take) begin
         in_frame_ff    <= in_frame_in;
         esc_pending_ff <= esc_pending_in;
         byte_count_ff  <= byte_count_in;
         crc_acc_ff     <= crc_acc_in;
      end
   end

   // Result queue pointers
   always_comb begin
      wr_ptr_in = res_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = res_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, res_push} - {1'b0, res_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[wr_ptr_ff] <= res_in;
      end
   end

   // Checks
   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_DEPTH)
      else $error("result queue overfilled");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (byte_count_ff == '0) && !esc_pending_ff)
      else $error("count or escape left over outside a frame");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      res_push && (res_in.frame_status != ST_NONE)
      |=> !in_frame_ff && (crc_acc_ff == CRC_INIT))
      else $error("frame end did not clear state");

   a_good_no_data: assert property (@(posedge clock) disable iff (reset)
      res_push && (res_in.frame_status == ST_GOOD) |-> !res_in.data_valid)
      else $error("good frame report carries a data byte");

endmodule

// ===== rtl/hdlc_stream_deframer_fcs_check.sv =====
// ----------------------------------------------------------------------------
// hdlc_stream_deframer_fcs_check
// HDLC byte-stream deframer: flag hunt, escape removal and FCS-16 check.
// ----------------------------------------------------------------------------
// Takes one line byte per clock while full is low and returns exactly one
// result word per byte. The front end classifies bytes into a two-entry
// queue; the back end keeps the frame state and updates the FCS with a
// combinational byte step, writing into a two-entry result queue. Sustained
// rate is one byte per cycle while pop keeps up; a byte is held in the front
// queue, then its result is registered into the result queue, from which it
// can be popped. With pop held low the block holds four bytes before full
// rises. The closed loop that sets this rate is the frame state and CRC
// register in the back end, updated once per byte. max_length may be written
// only while no bytes are in flight.
module hdlc_stream_deframer_fcs_check (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   // results
   output logic        empty,
   input  logic        pop,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [11:0] rsp_data_index,
   output logic [1:0]  rsp_frame_status,
   output logic [11:0] rsp_payload_len,
   // configuration
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);
   import hsd_pkg::*;

   item_type   item;
   logic       item_valid;
   logic       item_take;
   result_type res;

   hsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_rx_byte (req_rx_byte),
      .item_valid  (item_valid),
      .item_out    (item),
      .item_take   (item_take)
   );

   hsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item_in     (item),
      .item_take   (item_take),
      .empty       (empty),
      .pop         (pop),
      .res_out     (res)
   );

   // Result word onto the ports
   assign rsp_data_valid   = res.data_valid;
   assign rsp_data_byte    = res.data_byte;
   assign rsp_data_index   = res.data_index;
   assign rsp_frame_status = res.frame_status;
   assign rsp_payload_len  = res.payload_len;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HDLC stream deframer with FCS-16 check.
// ----------------------------------------------------------------------------
// A short table of line bytes comes first. Its obvious rows carry their
// expected words typed in; the rest are checked against a behavioural
// deframer kept here. Then mixed random traffic follows: mostly well-formed
// stuffed frames with correct or spoiled FCS, plus short frames, escape
// corner cases and line noise. max_length is rewritten between phases and
// covers 0, 3, small sizes, 4096 and all ones. Both sides idle at random,
// and the result side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
   import hsd_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PROBE_ROWS      = 26;
   localparam result_type IDLE_WORD = '0;

   // one row of the directed table
   typedef struct {
      logic [7:0] rx;
      bit         typed;
      result_type want;
   } probe_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_data_valid;
   logic [7:0]  rsp_data_byte;
   logic [11:0] rsp_data_index;
   logic [1:0]  rsp_frame_status;
   logic [11:0] rsp_payload_len;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   // behavioural deframer state
   logic              fr_open;
   logic              esc_pend;
   logic [CNT_W-1:0]  fr_count;
   logic [15:0]       fcs_reg;
   logic [CNT_W-1:0]  cap_cfg;

   result_type    deframe_q[$];
   probe_row_type probe_tab [PROBE_ROWS];
   int            mismatch_count = 0;
   int            items_sent = 0;
   int            quiet_cycles = 0;
   int            stall_left = 0;
   bit            snd_idle_on = 1'b1;
   bit            rcv_idle_on = 1'b1;
   bit            hold_req = 1'b0;

   hdlc_stream_deframer_fcs_check i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_rx_byte      (req_rx_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_index   (rsp_data_index),
      .rsp_frame_status (rsp_frame_status),
      .rsp_payload_len  (rsp_payload_len),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #1 clock = ~clock;

   // FCS-16 one byte, LSB first, feedback form
   function automatic logic [15:0] fcs16_next(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[k];
         c  = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic void close_frame();
      fr_open  = 1'b0;
      esc_pend = 1'b0;
      fr_count = '0;
      fcs_reg  = CRC_INIT;
   endfunction

   // expected word for one line byte; advances the frame state
   function automatic result_type deframe_predict(input logic [7:0] rx);
      result_type       r;
      logic [7:0]       d;
      logic [CNT_W-1:0] lim;
      r = IDLE_WORD;
      if (!fr_open) begin
         if (rx == FLAG_BYTE) begin
            fr_open  = 1'b1;
            esc_pend = 1'b0;
            fcs_reg  = CRC_INIT;
         end
      end else if (rx == FLAG_BYTE) begin
         // short frames leave everything as it was
         if (fr_count >= MIN_CLOSE) begin
            if (fcs_reg == CRC_GOOD) begin
               r.frame_status = ST_GOOD;
               r.payload_len  = IDX_W'(fr_count - FCS_LEN);
            end else begin
               r.frame_status = ST_CRC_ERR;
            end
            close_frame();
         end
      end else if (rx == ESC_BYTE) begin
         esc_pend = 1'b1;
      end else begin
         d = esc_pend ? (rx ^ ESC_XOR) : rx;
         esc_pend = 1'b0;
         r.data_valid = 1'b1;
         r.data_byte  = d;
         r.data_index = fr_count[IDX_W-1:0];
         fcs_reg  = fcs16_next(fcs_reg, d);
         fr_count = fr_count + CNT_W'(1);
         lim = (cap_cfg > CAP_LIMIT) ? CAP_LIMIT : cap_cfg;
         if (fr_count >= lim) begin
            r.frame_status = ST_OVERFLOW;
            close_frame();
         end
      end
      return r;
   endfunction

   function automatic result_type mk_word(input logic v, input logic [7:0] d,
                                          input logic [11:0] i, input frame_status_type s,
                                          input logic [11:0] l);
      return '{v, d, i, s, l};
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // payload byte biased towards the line codes and their stuffed forms
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return FLAG_BYTE;
         1: return ESC_BYTE;
         2: return FLAG_BYTE ^ ESC_XOR;
         3: return ESC_BYTE ^ ESC_XOR;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, msg);
   endfunction

   function automatic void field_check(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got)
         note_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
   endfunction

   // offer one line byte until the block takes it
   task automatic offer_byte(input logic [7:0] b);
      int gap;
      gap = snd_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      offer_byte(b);
      deframe_q.push_back(deframe_predict(b));
   endtask

   task automatic send_stuffed(input logic [7:0] b);
      if (b == FLAG_BYTE || b == ESC_BYTE) begin
         send_byte(ESC_BYTE);
         send_byte(b ^ ESC_XOR);
      end else begin
         send_byte(b);
      end
   endtask

   // flag, payload, FCS (optionally spoiled), flag
   task automatic send_frame(input int len, input bit spoil);
      logic [15:0] c;
      logic [7:0]  d;
      c = CRC_INIT;
      send_byte(FLAG_BYTE);
      repeat (len) begin
         d = pick_byte();
         c = fcs16_next(c, d);
         send_stuffed(d);
      end
      c = ~c;
      if (spoil) c = c ^ 16'($urandom_range(1, 65535));
      send_stuffed(c[7:0]);
      send_stuffed(c[15:8]);
      send_byte(FLAG_BYTE);
   endtask

   // mixed traffic until n more words have gone in
   task automatic run_mix(input int n);
      int goal;
      int pick;
      int len;
      goal = items_sent + n;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
         if (pick < 60) begin
            send_frame(len, 1'b0);
         end else if (pick < 72) begin
            send_frame(len, 1'b1);
         end else if (pick < 82) begin
            // flag after too few bytes
            send_byte(FLAG_BYTE);
            repeat ($urandom_range(0, 2)) send_stuffed(pick_byte());
            send_byte(FLAG_BYTE);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 8)) send_byte(pick_byte());
         end else if (pick < 95) begin
            // dangling escape, possibly repeated, before the closing flag
            send_byte(FLAG_BYTE);
            repeat ($urandom_range(3, 6)) send_stuffed(pick_byte());
            send_byte(ESC_BYTE);
            if ($urandom_range(0, 1)) send_byte(ESC_BYTE);
            send_byte(FLAG_BYTE);
         end else begin
            // escape held across an ignored short-frame flag
            send_byte(FLAG_BYTE);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(ESC_BYTE);
            send_byte(FLAG_BYTE);
            send_byte(pick_byte());
         end
      end
   endtask

   // drain, then rewrite max_length with nothing in flight
   task automatic write_cap(input logic [12:0] v);
      push <= 1'b0;
      while (deframe_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_cfg = v;
   endtask

   // result side: random stalls plus the one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_req) begin
         hold_req   = 1'b0;
         stall_left = HOLD_OFF_CYCLES;
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (rcv_idle_on && $urandom_range(0, 99) < 25) begin
         stall_left = pick_gap();
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // compare each popped word with the oldest expectation
   always @(posedge clock) begin : word_check
      result_type want;
      if (!reset && pop && !empty) begin
         if (deframe_q.size() == 0) begin
            note_mismatch($sformatf("word with nothing expected: valid %0d byte 0x%0h status %0d",
                                    rsp_data_valid, rsp_data_byte, rsp_frame_status));
         end else begin
            want = deframe_q.pop_front();
            field_check("data_valid",   want.data_valid,   rsp_data_valid);
            field_check("data_byte",    want.data_byte,    rsp_data_byte);
            field_check("data_index",   want.data_index,   rsp_data_index);
            field_check("frame_status", want.frame_status, rsp_frame_status);
            field_check("payload_len",  want.payload_len,  rsp_payload_len);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cap_cfg = CAP_LIMIT;
      close_frame();

      // directed: hunt, escapes, short frames, CRC error, known good frame
      probe_tab = '{
         '{8'h00,           1'b1, IDLE_WORD},
         '{ESC_BYTE,        1'b1, IDLE_WORD},
         '{FLAG_BYTE,       1'b1, IDLE_WORD},
         '{FLAG_BYTE,       1'b1, IDLE_WORD},
         '{ESC_BYTE,        1'b1, IDLE_WORD},
         '{ESC_BYTE,        1'b1, IDLE_WORD},
         '{8'h5E,           1'b1, mk_word(1'b1, FLAG_BYTE, 12'd0, ST_NONE, 12'd0)},
         '{FLAG_BYTE,       1'b1, IDLE_WORD},
         '{8'h00,           1'b1, mk_word(1'b1, 8'h00, 12'd1, ST_NONE, 12'd0)},
         '{8'hFF,           1'b1, mk_word(1'b1, 8'hFF, 12'd2, ST_NONE, 12'd0)},
         '{ESC_BYTE,        1'b1, IDLE_WORD},
         '{8'h5D,           1'b1, mk_word(1'b1, ESC_BYTE, 12'd3, ST_NONE, 12'd0)},
         '{FLAG_BYTE,       1'b0, IDLE_WORD},
         '{FLAG_BYTE,       1'b1, IDLE_WORD},
         '{8'h31,           1'b1, mk_word(1'b1, 8'h31, 12'd0, ST_NONE, 12'd0)},
         '{8'h32,           1'b1, mk_word(1'b1, 8'h32, 12'd1, ST_NONE, 12'd0)},
         '{8'h33,           1'b1, mk_word(1'b1, 8'h33, 12'd2, ST_NONE, 12'd0)},
         '{8'h34,           1'b1, mk_word(1'b1, 8'h34, 12'd3, ST_NONE, 12'd0)},
         '{8'h35,           1'b1, mk_word(1'b1, 8'h35, 12'd4, ST_NONE, 12'd0)},
         '{8'h36,           1'b1, mk_word(1'b1, 8'h36, 12'd5, ST_NONE, 12'd0)},
         '{8'h37,           1'b1, mk_word(1'b1, 8'h37, 12'd6, ST_NONE, 12'd0)},
         '{8'h38,           1'b1, mk_word(1'b1, 8'h38, 12'd7, ST_NONE, 12'd0)},
         '{8'h39,           1'b1, mk_word(1'b1, 8'h39, 12'd8, ST_NONE, 12'd0)},
         '{8'h6E,           1'b0, IDLE_WORD},
         '{8'h90,           1'b0, IDLE_WORD},
         '{FLAG_BYTE,       1'b1, mk_word(1'b0, 8'h00, 12'd0, ST_GOOD, 12'd9)}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_tab[i]) begin
         offer_byte(probe_tab[i].rx);
         if (probe_tab[i].typed) begin
            void'(deframe_predict(probe_tab[i].rx));
            deframe_q.push_back(probe_tab[i].want);
         end else begin
            deframe_q.push_back(deframe_predict(probe_tab[i].rx));
         end
      end

      // reset capacity
      run_mix(200);

      // smallest sane capacity: every frame long enough to close overflows instead
      write_cap(13'd3);
      run_mix(60);

      // zero capacity: first stored byte drops the frame
      write_cap(13'd0);
      run_mix(40);

      // all ones, clamped to the index span; a long frame stays inside it
      write_cap(13'h1FFF);
      snd_idle_on = 1'b0;
      rcv_idle_on = 1'b0;
      send_byte(FLAG_BYTE);
      repeat (100) send_stuffed(8'($urandom_range(0, 255)));
      send_byte(FLAG_BYTE);
      run_mix(40);

      // small capacity, input backs up while the result side holds off
      write_cap(13'd24);
      rcv_idle_on = 1'b1;
      hold_req = 1'b1;
      run_mix(80);
      snd_idle_on = 1'b1;

      repeat (3) begin
         write_cap(13'($urandom_range(4, 40)));
         run_mix(50);
      end

      write_cap(13'd4096);
      run_mix(100);

      push <= 1'b0;
      while (deframe_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hsd_pkg.sv
rtl/hsd_front.sv
rtl/hsd_back.sv
rtl/hdlc_stream_deframer_fcs_check.sv
tb/tb_top.sv
